// File: sv/fdsa_pkg.sv
package fdsa_pkg;

    localparam int DIR_ENTRIES_DEF = 32;
    localparam int MAP_SECTORS_DEF = 512;
    localparam int NAME_BYTES_DEF  = 8;

    // start field reaches sectors below this
    localparam int START_LIMIT = 512;

    localparam logic [7:0] KIND_TEXT = 8'h74;

    typedef enum logic [2:0] {
        CMD_LOOKUP = 3'd0,
        CMD_CREATE = 3'd1,
        CMD_DELETE = 3'd2,
        CMD_WRITE  = 3'd3,
        CMD_READ   = 3'd4,
        CMD_SETMAP = 3'd5
    } fdsa_cmd_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_NOT_TEXT  = 3'd2,
        ST_EXISTS    = 3'd3,
        ST_DIR_FULL  = 3'd4,
        ST_DISK_FULL = 3'd5
    } fdsa_status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_MAP_RD,
        S_MAP_CHK,
        S_FREE,
        S_READ_WAIT,
        S_DONE
    } fdsa_state_t;

    typedef struct packed {
        logic [2:0]  command;
        logic [63:0] file_name;
        logic [4:0]  slot;
        logic [7:0]  kind_byte;
        logic [8:0]  first_sector;
        logic [7:0]  run_length;
        logic        used_flag;
    } fdsa_in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [4:0]  entry_slot;
        logic [63:0] entry_name;
        logic [7:0]  entry_kind;
        logic [8:0]  entry_start;
        logic [7:0]  entry_length;
        logic        entry_occupied;
    } fdsa_out_t;

    typedef struct packed {
        logic [63:0] name;
        logic [7:0]  kind;
        logic [8:0]  start;
        logic [7:0]  length;
    } fdsa_entry_t;

    function automatic logic [63:0] name_mask(input int nb);
        logic [63:0] m;
        m = '0;
        for (int j = 0; j < 8; j++) begin
            if (j < nb) begin
                m[8*j +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

    // keep bytes up to the first zero byte, within nb bytes
    function automatic logic [63:0] cut_name(input logic [63:0] v, input int nb);
        logic [63:0] r;
        logic        stop;
        r    = '0;
        stop = 1'b0;
        for (int j = 0; j < 8; j++) begin
            if (j >= nb || v[8*j +: 8] == 8'h00) begin
                stop = 1'b1;
            end
            if (!stop) begin
                r[8*j +: 8] = v[8*j +: 8];
            end
        end
        return r;
    endfunction

    function automatic fdsa_out_t mk_result(input fdsa_status_t st, input logic [4:0] idx,
                                            input fdsa_entry_t e);
        fdsa_out_t r;
        r.status         = st;
        r.entry_slot     = idx;
        r.entry_name     = e.name;
        r.entry_kind     = e.kind;
        r.entry_start    = e.start;
        r.entry_length   = e.length;
        r.entry_occupied = (e.name[7:0] != 8'h00);
        return r;
    endfunction

    function automatic fdsa_out_t mk_empty(input fdsa_status_t st);
        fdsa_out_t r;
        r        = '0;
        r.status = st;
        return r;
    endfunction

endpackage

// File: sv/flat_directory_sector_allocator.sv
// Channel | Ports                     | Moves
// input   | s_valid s_ready s_data    | one command request
// result  | m_valid m_ready m_data    | one status and entry per request
//
// Lookup and delete scan the directory one entry after another;
// delete then frees one sector a cycle over the entry's run. Create scans the directory,
// then the sector map one sector after another until a free one is found or the scan limit
// is reached. Write, set map bit and unused commands finish from the exec state; read adds a wait state.
// The shared directory read port sets the scan pace.
// After reset the sector map is cleared with s_ready low.
// A finished result waits in the output register; the next request is taken meanwhile.
module flat_directory_sector_allocator #(
    parameter int DIR_ENTRIES = fdsa_pkg::DIR_ENTRIES_DEF,
    parameter int MAP_SECTORS = fdsa_pkg::MAP_SECTORS_DEF,
    parameter int NAME_BYTES  = fdsa_pkg::NAME_BYTES_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  fdsa_pkg::fdsa_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output fdsa_pkg::fdsa_out_t m_data
);
    import fdsa_pkg::*;

    localparam int IW = $clog2(DIR_ENTRIES);
    localparam int MW = $clog2(MAP_SECTORS);
    localparam int SCAN_LIMIT = (MAP_SECTORS < START_LIMIT) ? MAP_SECTORS : START_LIMIT;
    localparam logic [63:0] NMASK = name_mask(NAME_BYTES);

    fdsa_state_t state_reg, state_next;
    fdsa_in_t    req_reg, req_next;
    logic [63:0] key_reg, key_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [IW-1:0] free_idx_reg, free_idx_next;
    logic          free_found_reg, free_found_next;
    logic [MW-1:0] sec_reg, sec_next;
    logic [7:0]    run_reg, run_next;
    fdsa_entry_t   ent_reg, ent_next;
    fdsa_out_t     res_reg, res_next;
    fdsa_out_t     out_reg, out_next;
    logic          m_valid_reg, m_valid_next;

    logic          dir_wr_en;
    logic [IW-1:0] dir_wr_addr;
    fdsa_entry_t   dir_wr_data;
    logic [IW-1:0] dir_rd_addr;
    fdsa_entry_t   dir_rd_data;

    logic          map_wr_en;
    logic [MW-1:0] map_wr_addr;
    logic          map_wr_data;
    logic          map_rd_data;
    logic          map_busy;

    logic          occ;
    logic          slot_ok;
    logic [9:0]    sec_sum;
    fdsa_entry_t   e;

    fdsa_dir_mem #(.DIR_ENTRIES(DIR_ENTRIES)) u_dir (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (dir_wr_en),
        .wr_addr (dir_wr_addr),
        .wr_data (dir_wr_data),
        .rd_addr (dir_rd_addr),
        .rd_data (dir_rd_data)
    );

    fdsa_map_mem #(.MAP_SECTORS(MAP_SECTORS)) u_map (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (map_wr_en),
        .wr_addr (map_wr_addr),
        .wr_data (map_wr_data),
        .rd_addr (sec_reg),
        .rd_data (map_rd_data),
        .busy    (map_busy)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg        <= req_next;
        key_reg        <= key_next;
        idx_reg        <= idx_next;
        free_idx_reg   <= free_idx_next;
        free_found_reg <= free_found_next;
        sec_reg        <= sec_next;
        run_reg        <= run_next;
        ent_reg        <= ent_next;
        res_reg        <= res_next;
        out_reg        <= out_next;
    end

    assign s_ready = (state_reg == S_IDLE) && !map_busy;
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    assign occ     = (dir_rd_data.name[7:0] != 8'h00);
    assign slot_ok = int'(req_reg.slot) < DIR_ENTRIES;
    assign sec_sum = 10'(ent_reg.start) + 10'(run_reg);

    always_comb begin
        state_next      = state_reg;
        req_next        = req_reg;
        key_next        = key_reg;
        idx_next        = idx_reg;
        free_idx_next   = free_idx_reg;
        free_found_next = free_found_reg;
        sec_next        = sec_reg;
        run_next        = run_reg;
        ent_next        = ent_reg;
        res_next        = res_reg;
        out_next        = out_reg;
        m_valid_next    = m_valid_reg;
        dir_wr_en       = 1'b0;
        dir_wr_addr     = idx_reg;
        dir_wr_data     = '0;
        dir_rd_addr     = idx_reg;
        map_wr_en       = 1'b0;
        map_wr_addr     = sec_reg;
        map_wr_data     = 1'b0;
        e               = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid && s_ready) begin
                    req_next   = s_data;
                    key_next   = cut_name(s_data.file_name, NAME_BYTES);
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                idx_next        = '0;
                free_found_next = 1'b0;
                unique case (req_reg.command)
                    CMD_LOOKUP, CMD_CREATE, CMD_DELETE: begin
                        state_next = S_SCAN_RD;
                    end
                    CMD_WRITE: begin
                        if (slot_ok) begin
                            e.name      = req_reg.file_name & NMASK;
                            e.kind      = req_reg.kind_byte;
                            e.start     = req_reg.first_sector;
                            e.length    = req_reg.run_length;
                            dir_wr_en   = 1'b1;
                            dir_wr_addr = IW'(req_reg.slot);
                            dir_wr_data = e;
                            res_next    = mk_result(ST_OK, req_reg.slot, e);
                        end else begin
                            res_next = mk_empty(ST_NOT_FOUND);
                        end
                        state_next = S_DONE;
                    end
                    CMD_READ: begin
                        if (slot_ok) begin
                            dir_rd_addr = IW'(req_reg.slot);
                            state_next  = S_READ_WAIT;
                        end else begin
                            res_next   = mk_empty(ST_NOT_FOUND);
                            state_next = S_DONE;
                        end
                    end
                    CMD_SETMAP: begin
                        if (int'(req_reg.first_sector) < MAP_SECTORS) begin
                            map_wr_en   = 1'b1;
                            map_wr_addr = MW'(req_reg.first_sector);
                            map_wr_data = req_reg.used_flag;
                        end
                        res_next             = mk_empty(ST_OK);
                        res_next.entry_start = req_reg.first_sector;
                        state_next           = S_DONE;
                    end
                    default: begin
                        res_next   = mk_empty(ST_OK);
                        state_next = S_DONE;
                    end
                endcase
            end
            S_READ_WAIT: begin
                res_next   = mk_result(ST_OK, req_reg.slot, dir_rd_data);
                state_next = S_DONE;
            end
            S_SCAN_RD: begin
                state_next = S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                state_next = S_SCAN_RD;
                idx_next   = idx_reg + 1'b1;
                if (req_reg.command == CMD_CREATE) begin
                    if (!occ) begin
                        if (!free_found_reg) begin
                            free_found_next = 1'b1;
                            free_idx_next   = idx_reg;
                        end
                        if (idx_reg == IW'(DIR_ENTRIES - 1)) begin
                            sec_next   = '0;
                            state_next = S_MAP_RD;
                        end
                    end else if (cut_name(dir_rd_data.name, NAME_BYTES) == key_reg) begin
                        res_next   = mk_result(ST_EXISTS, 5'(idx_reg), dir_rd_data);
                        state_next = S_DONE;
                    end else if (idx_reg == IW'(DIR_ENTRIES - 1)) begin
                        if (free_found_reg) begin
                            sec_next   = '0;
                            state_next = S_MAP_RD;
                        end else begin
                            res_next   = mk_empty(ST_DIR_FULL);
                            state_next = S_DONE;
                        end
                    end
                end else if (occ && dir_rd_data.name == key_reg) begin
                    if (req_reg.command == CMD_LOOKUP) begin
                        res_next = mk_result((dir_rd_data.kind == KIND_TEXT) ? ST_OK
                                             : ST_NOT_TEXT, 5'(idx_reg), dir_rd_data);
                        state_next = S_DONE;
                    end else begin
                        // delete: drop the first name byte, then free the run
                        e             = dir_rd_data;
                        e.name[7:0]   = 8'h00;
                        dir_wr_en     = 1'b1;
                        dir_wr_addr   = idx_reg;
                        dir_wr_data   = e;
                        ent_next      = e;
                        idx_next      = idx_reg;
                        run_next      = '0;
                        state_next    = S_FREE;
                    end
                end else if (idx_reg == IW'(DIR_ENTRIES - 1)) begin
                    res_next   = mk_empty(ST_NOT_FOUND);
                    state_next = S_DONE;
                end
            end
            S_FREE: begin
                if (run_reg == ent_reg.length) begin
                    res_next   = mk_result(ST_OK, 5'(idx_reg), ent_reg);
                    state_next = S_DONE;
                end else begin
                    if (int'(sec_sum) < MAP_SECTORS) begin
                        map_wr_en   = 1'b1;
                        map_wr_addr = MW'(sec_sum);
                        map_wr_data = 1'b0;
                    end
                    run_next = run_reg + 1'b1;
                end
            end
            S_MAP_RD: begin
                state_next = S_MAP_CHK;
            end
            S_MAP_CHK: begin
                if (!map_rd_data) begin
                    e.name      = key_reg;
                    e.kind      = KIND_TEXT;
                    e.start     = 9'(sec_reg);
                    e.length    = 8'd1;
                    dir_wr_en   = 1'b1;
                    dir_wr_addr = free_idx_reg;
                    dir_wr_data = e;
                    map_wr_en   = 1'b1;
                    map_wr_addr = sec_reg;
                    map_wr_data = 1'b1;
                    res_next    = mk_result(ST_OK, 5'(free_idx_reg), e);
                    state_next  = S_DONE;
                end else if (sec_reg == MW'(SCAN_LIMIT - 1)) begin
                    res_next   = mk_empty(ST_DISK_FULL);
                    state_next = S_DONE;
                end else begin
                    sec_next   = sec_reg + 1'b1;
                    state_next = S_MAP_RD;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    out_next     = res_reg;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: sv/fdsa_dir_mem.sv
module fdsa_dir_mem #(
    parameter int DIR_ENTRIES = fdsa_pkg::DIR_ENTRIES_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           wr_en,
    input  logic [$clog2(DIR_ENTRIES)-1:0] wr_addr,
    input  fdsa_pkg::fdsa_entry_t          wr_data,
    input  logic [$clog2(DIR_ENTRIES)-1:0] rd_addr,
    output fdsa_pkg::fdsa_entry_t          rd_data
);
    import fdsa_pkg::*;

    fdsa_entry_t            mem [DIR_ENTRIES];
    logic [DIR_ENTRIES-1:0] valid_reg;
    fdsa_entry_t            data_reg;
    logic                   rd_valid_reg;

    // entries never written read as an empty entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            rd_valid_reg <= valid_reg[rd_addr];
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= mem[rd_addr];
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    assign rd_data = rd_valid_reg ? data_reg : '0;

endmodule

// File: sv/fdsa_map_mem.sv
module fdsa_map_mem #(
    parameter int MAP_SECTORS = fdsa_pkg::MAP_SECTORS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           wr_en,
    input  logic [$clog2(MAP_SECTORS)-1:0] wr_addr,
    input  logic                           wr_data,
    input  logic [$clog2(MAP_SECTORS)-1:0] rd_addr,
    output logic                           rd_data,
    output logic                           busy
);
    import fdsa_pkg::*;

    localparam int MW = $clog2(MAP_SECTORS);

    logic          mem [MAP_SECTORS];
    logic [MW-1:0] clr_reg;
    logic          busy_reg;
    logic          rd_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b1;
            clr_reg  <= '0;
        end else if (busy_reg) begin
            clr_reg <= clr_reg + 1'b1;
            if (clr_reg == MW'(MAP_SECTORS - 1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
        if (busy_reg) begin
            mem[clr_reg] <= 1'b0;
        end else if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = busy_reg;

endmodule

// File: dv/tb_flat_directory_sector_allocator.sv
`timescale 1ns / 100ps

module tb_flat_directory_sector_allocator;
    import fdsa_pkg::*;

    localparam int NDIR = DIR_ENTRIES_DEF;
    localparam int NMAP = MAP_SECTORS_DEF;
    localparam int NB   = NAME_BYTES_DEF;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    fdsa_in_t  s_data;
    logic      m_valid;
    logic      m_ready;
    fdsa_out_t m_data;

    flat_directory_sector_allocator i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // predictor copy of the directory and map
    logic [63:0] dir_name  [NDIR];
    logic [7:0]  dir_kind  [NDIR];
    logic [8:0]  dir_start [NDIR];
    logic [7:0]  dir_len   [NDIR];
    logic        sect_used [NMAP];

    fdsa_in_t  request_queue [$];
    fdsa_out_t pending_status [$];
    int        error_count   = 0;
    int        requests_sent = 0;
    int        replies_seen  = 0;
    bit        calm;
    bit        s_accepted;
    int        s_idle_left;
    int        m_stall_left;

    // short list of names so creates and lookups collide often
    logic [63:0] name_pool [8];

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic [63:0] trim_name(input logic [63:0] v);
        logic [63:0] r;
        logic        stop;
        r    = '0;
        stop = 1'b0;
        for (int j = 0; j < 8; j++) begin
            if (j >= NB || v[8*j +: 8] == 8'h00) begin
                stop = 1'b1;
            end
            if (!stop) begin
                r[8*j +: 8] = v[8*j +: 8];
            end
        end
        return r;
    endfunction

    function automatic bit slot_taken(input int i);
        return dir_name[i][7:0] != 8'h00;
    endfunction

    function automatic fdsa_out_t entry_reply(input fdsa_status_t st, input int i);
        fdsa_out_t r;
        r                = '0;
        r.status         = st;
        r.entry_slot     = i[4:0];
        r.entry_name     = dir_name[i];
        r.entry_kind     = dir_kind[i];
        r.entry_start    = dir_start[i];
        r.entry_length   = dir_len[i];
        r.entry_occupied = slot_taken(i);
        return r;
    endfunction

    function automatic fdsa_out_t bare_reply(input fdsa_status_t st);
        fdsa_out_t r;
        r        = '0;
        r.status = st;
        return r;
    endfunction

    function automatic int find_entry(input logic [63:0] nm);
        for (int i = 0; i < NDIR; i++) begin
            if (slot_taken(i) && dir_name[i] == nm) begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic fdsa_out_t apply_command(input fdsa_in_t rq);
        logic [63:0] nm;
        int          idx;
        int          free_ent;
        int          free_sec;
        int          s;
        nm = trim_name(rq.file_name);
        case (rq.command)
            CMD_LOOKUP: begin
                idx = find_entry(nm);
                if (idx < 0) begin
                    return bare_reply(ST_NOT_FOUND);
                end
                return entry_reply(dir_kind[idx] == KIND_TEXT ? ST_OK : ST_NOT_TEXT, idx);
            end
            CMD_CREATE: begin
                free_ent = -1;
                free_sec = -1;
                for (int i = 0; i < NDIR; i++) begin
                    if (!slot_taken(i)) begin
                        if (free_ent < 0) begin
                            free_ent = i;
                        end
                    end else if (trim_name(dir_name[i]) == nm) begin
                        return entry_reply(ST_EXISTS, i);
                    end
                end
                if (free_ent < 0) begin
                    return bare_reply(ST_DIR_FULL);
                end
                for (int i = 0; i < NMAP && i < START_LIMIT; i++) begin
                    if (!sect_used[i] && free_sec < 0) begin
                        free_sec = i;
                    end
                end
                if (free_sec < 0) begin
                    return bare_reply(ST_DISK_FULL);
                end
                dir_name[free_ent]  = nm;
                dir_kind[free_ent]  = KIND_TEXT;
                dir_start[free_ent] = free_sec[8:0];
                dir_len[free_ent]   = 8'd1;
                sect_used[free_sec] = 1'b1;
                return entry_reply(ST_OK, free_ent);
            end
            CMD_DELETE: begin
                idx = find_entry(nm);
                if (idx < 0) begin
                    return bare_reply(ST_NOT_FOUND);
                end
                dir_name[idx][7:0] = 8'h00;
                for (int i = 0; i < dir_len[idx]; i++) begin
                    s = dir_start[idx] + i;
                    if (s < NMAP) begin
                        sect_used[s] = 1'b0;
                    end
                end
                return entry_reply(ST_OK, idx);
            end
            CMD_WRITE: begin
                if (rq.slot >= NDIR) begin
                    return bare_reply(ST_NOT_FOUND);
                end
                dir_name[rq.slot]  = rq.file_name & name_mask(NB);
                dir_kind[rq.slot]  = rq.kind_byte;
                dir_start[rq.slot] = rq.first_sector;
                dir_len[rq.slot]   = rq.run_length;
                return entry_reply(ST_OK, rq.slot);
            end
            CMD_READ: begin
                if (rq.slot >= NDIR) begin
                    return bare_reply(ST_NOT_FOUND);
                end
                return entry_reply(ST_OK, rq.slot);
            end
            CMD_SETMAP: begin
                if (rq.first_sector < NMAP) begin
                    sect_used[rq.first_sector] = rq.used_flag;
                end
                apply_command             = bare_reply(ST_OK);
                apply_command.entry_start = rq.first_sector;
                return apply_command;
            end
            default: return bare_reply(ST_OK);
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH request %0d: %s got %h want %h", replies_seen, what, got, want);
        error_count++;
    endtask

    function automatic fdsa_in_t random_request(input fdsa_cmd_t c);
        fdsa_in_t rq;
        rq.command      = c;
        rq.file_name    = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom}
                                                      : name_pool[$urandom_range(0, 7)];
        rq.slot         = 5'($urandom_range(0, 31));
        rq.kind_byte    = ($urandom_range(0, 1) == 1) ? KIND_TEXT : 8'($urandom);
        rq.first_sector = 9'($urandom_range(0, 511));
        rq.run_length   = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 4));
        rq.used_flag    = 1'($urandom_range(0, 1));
        return rq;
    endfunction

    function automatic fdsa_in_t make_request(input logic [2:0] c, input logic [63:0] nm,
                                              input logic [4:0] sl, input logic [7:0] kd,
                                              input logic [8:0] fs, input logic [7:0] rl,
                                              input logic uf);
        fdsa_in_t rq;
        rq.command      = c;
        rq.file_name    = nm;
        rq.slot         = sl;
        rq.kind_byte    = kd;
        rq.first_sector = fs;
        rq.run_length   = rl;
        rq.used_flag    = uf;
        return rq;
    endfunction

    // driver: inputs move on the falling edge
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid      <= 1'b0;
            s_data       <= '0;
            m_ready      <= 1'b0;
            s_idle_left  <= 0;
            m_stall_left <= 0;
        end else begin
            // a held request moves on only once taken at the last rising edge
            if (!s_valid || s_accepted) begin
                if (s_idle_left > 0) begin
                    s_idle_left <= s_idle_left - 1;
                    s_valid     <= 1'b0;
                end else if (request_queue.size() > 0) begin
                    s_data  <= request_queue.pop_front();
                    s_valid <= 1'b1;
                    if (!calm && $urandom_range(0, 5) == 0) begin
                        s_idle_left <= $urandom_range(1, 13);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
            if (m_stall_left > 0) begin
                m_stall_left <= m_stall_left - 1;
                m_ready      <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (!calm && $urandom_range(0, 7) == 0) begin
                    m_stall_left <= $urandom_range(1, 13);
                end
            end
        end
    end

    // monitor: predict on accepted requests, check accepted results
    always @(posedge aclk) begin
        fdsa_out_t want;
        s_accepted <= aresetn && s_valid && s_ready;
        if (aresetn && s_valid && s_ready) begin
            pending_status.push_back(apply_command(s_data));
            requests_sent++;
        end
        if (aresetn && m_valid && m_ready) begin
            replies_seen++;
            if (pending_status.size() == 0) begin
                report_mismatch("unexpected result", m_data.status, 0);
            end else begin
                want = pending_status.pop_front();
                if (m_data.status !== want.status)
                    report_mismatch("status", m_data.status, want.status);
                if (m_data.entry_slot !== want.entry_slot)
                    report_mismatch("entry_slot", m_data.entry_slot, want.entry_slot);
                if (m_data.entry_name !== want.entry_name)
                    report_mismatch("entry_name", m_data.entry_name, want.entry_name);
                if (m_data.entry_kind !== want.entry_kind)
                    report_mismatch("entry_kind", m_data.entry_kind, want.entry_kind);
                if (m_data.entry_start !== want.entry_start)
                    report_mismatch("entry_start", m_data.entry_start, want.entry_start);
                if (m_data.entry_length !== want.entry_length)
                    report_mismatch("entry_length", m_data.entry_length, want.entry_length);
                if (m_data.entry_occupied !== want.entry_occupied)
                    report_mismatch("entry_occupied", m_data.entry_occupied,
                                    want.entry_occupied);
            end
        end
    end

    initial begin
        #40ms;
        $display("timeout with %0d results outstanding", pending_status.size());
        $display("flat_directory_sector_allocator test failed");
        $finish;
    end

    initial begin
        fdsa_cmd_t c;
        int        r;
        for (int i = 0; i < NDIR; i++) begin
            dir_name[i]  = '0;
            dir_kind[i]  = '0;
            dir_start[i] = '0;
            dir_len[i]   = '0;
        end
        for (int i = 0; i < NMAP; i++) begin
            sect_used[i] = 1'b0;
        end
        name_pool[0] = 64'h0000_0000_0000_0061;
        name_pool[1] = 64'h0000_0000_0074_6f6f;
        name_pool[2] = 64'h6867_6665_6463_6261;
        name_pool[3] = 64'h7700_0000_0074_6f6f; // junk after the terminator
        name_pool[4] = 64'h0000_0000_0000_0000;
        name_pool[5] = 64'hffff_ffff_ffff_ffff;
        name_pool[6] = 64'h0000_0000_0000_3162;
        name_pool[7] = 64'h0000_7a79_0000_6362;
        aresetn      = 1'b0;
        calm         = 1'b0;

        // directed opening
        request_queue.push_back(make_request(CMD_LOOKUP, name_pool[1], 0, 0, 0, 0, 0));
        request_queue.push_back(make_request(CMD_CREATE, name_pool[1], 0, 0, 0, 0, 0));
        request_queue.push_back(make_request(CMD_CREATE, name_pool[3], 0, 0, 0, 0, 0));
        request_queue.push_back(make_request(CMD_LOOKUP, name_pool[3], 0, 0, 0, 0, 0));
        request_queue.push_back(make_request(CMD_CREATE, name_pool[4], 0, 0, 0, 0, 0));
        request_queue.push_back(make_request(CMD_WRITE, name_pool[5], 31, 8'hff, 9'd511,
                                             8'hff, 0));
        request_queue.push_back(make_request(CMD_LOOKUP, name_pool[5], 0, 0, 0, 0, 0));
        request_queue.push_back(make_request(CMD_DELETE, name_pool[5], 0, 0, 0, 0, 0));
        request_queue.push_back(make_request(CMD_READ, 0, 31, 0, 0, 0, 0));
        request_queue.push_back(make_request(CMD_WRITE, name_pool[2], 2, KIND_TEXT, 9'd0,
                                             8'd3, 0));
        request_queue.push_back(make_request(CMD_SETMAP, 0, 0, 0, 9'd511, 0, 1'b1));
        request_queue.push_back(make_request(CMD_SETMAP, 0, 0, 0, 9'd0, 0, 1'b0));
        request_queue.push_back(make_request(CMD_DELETE, name_pool[2], 0, 0, 0, 0, 0));
        request_queue.push_back(make_request(CMD_DELETE, name_pool[2], 0, 0, 0, 0, 0));
        request_queue.push_back(make_request(3'd6, 64'hffff_ffff_ffff_ffff, 31, 8'hff,
                                             9'd511, 8'hff, 1'b1));
        request_queue.push_back(make_request(3'd7, 0, 0, 0, 0, 0, 0));
        // fill the directory so that create reports it full
        for (int i = 0; i < NDIR; i++) begin
            request_queue.push_back(make_request(CMD_WRITE, 64'h30 + i, i[4:0], KIND_TEXT,
                                                 9'd400, 8'd1, 0));
        end
        request_queue.push_back(make_request(CMD_CREATE, name_pool[6], 0, 0, 0, 0, 0));
        // reopen room: clear every slot
        for (int i = 0; i < NDIR; i++) begin
            request_queue.push_back(make_request(CMD_WRITE, 0, i[4:0], 0, 0, 0, 0));
        end
        request_queue.push_back(make_request(CMD_WRITE, 64'h61, 0, KIND_TEXT, 9'd0,
                                             8'd255, 0));
        request_queue.push_back(make_request(CMD_DELETE, 64'h61, 0, 0, 0, 0, 0));

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // random mix weighted towards create/lookup/delete on a small name pool
        for (int n = 0; n < 320; n++) begin
            r = $urandom_range(0, 99);
            if (r < 25)      c = CMD_CREATE;
            else if (r < 45) c = CMD_LOOKUP;
            else if (r < 62) c = CMD_DELETE;
            else if (r < 75) c = CMD_WRITE;
            else if (r < 87) c = CMD_READ;
            else             c = CMD_SETMAP;
            request_queue.push_back(random_request(c));
        end

        wait (request_queue.size() < 60);
        calm = 1'b1;
        wait (request_queue.size() == 0 && !s_valid);
        wait (pending_status.size() == 0);
        repeat (200) @(posedge aclk);
        $display("ran %0d commands through an empty and a full directory, stalls both sides",
                 requests_sent);
        $display("%0d results checked, %0d mismatches", replies_seen, error_count);
        if (error_count == 0 && pending_status.size() == 0) begin
            $display("flat_directory_sector_allocator test passed");
        end else begin
            $display("flat_directory_sector_allocator test failed");
        end
        $finish;
    end

endmodule

// File: flat_directory_sector_allocator.f
sv/fdsa_pkg.sv
sv/fdsa_dir_mem.sv
sv/fdsa_map_mem.sv
sv/flat_directory_sector_allocator.sv
dv/tb_flat_directory_sector_allocator.sv
